[sv/palette_dither_engine_unit_macros.svh]
// ---------------------------------------------------------------------------
// Palette dither engine assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef PALETTE_DITHER_ENGINE_UNIT_MACROS_SVH
`define PALETTE_DITHER_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define PDE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PDE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/pde_pkg.sv]
// ---------------------------------------------------------------------------
// Palette dither engine package
// Shared constants, codes, the Bayer table and controller/datapath types.
// ---------------------------------------------------------------------------
package pde_pkg;

	localparam int MAX_WIDTH_DEF     = 1024;
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int ROWS              = 3;
	localparam int CH_W              = 10;
	localparam int ERR_W             = 3 * CH_W;
	localparam int COL_W             = 8;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 16;
	localparam int IMG_W_W           = 11;
	localparam int IMG_H_W           = 16;
	localparam int PAL_CNT_W         = 9;

	localparam logic [IMG_W_W-1:0]   WIDTH_RST  = 11'd1024;
	localparam logic [IMG_H_W-1:0]   HEIGHT_RST = 16'd1;
	localparam logic [PAL_CNT_W-1:0] PCOUNT_RST = 9'd256;

	typedef enum logic [1:0] {
		MODE_PASS  = 2'd0,
		MODE_FS    = 2'd1,
		MODE_ATK   = 2'd2,
		MODE_BAYER = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE   = 3'd0,
		CFG_WIDTH  = 3'd1,
		CFG_HEIGHT = 3'd2,
		CFG_PCOUNT = 3'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_PAL   = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADJ,
		ST_SEARCH,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_PAL,
		ST_ERR,
		ST_SP_RD,
		ST_SP_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic adj;
		logic srch_issue;
		logic best_load;
		logic err_calc;
		logic sp_rd;
		logic sp_wr;
		logic tgt_next;
		logic finish;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		logic  op_pixel;
		mode_t mode;
		logic  srch_last;
		logic  tgt_en;
		logic  tgt_last;
		logic  out_free;
		logic  last_col;
		logic  clr_last;
	} sts_t;

	localparam logic [3:0] BAYER [16] = '{
		4'd0,  4'd8,  4'd2,  4'd10,
		4'd12, 4'd4,  4'd14, 4'd6,
		4'd3,  4'd11, 4'd1,  4'd9,
		4'd15, 4'd7,  4'd13, 4'd5
	};

	// divide by a power of two, truncating toward zero
	function automatic logic signed [12:0] div_pow2(input logic signed [12:0] v,
			input logic [2:0] sh);
		logic signed [12:0] bias;
		bias = (v < 0) ? ((13'sd1 <<< sh) - 13'sd1) : 13'sd0;
		return (v + bias) >>> sh;
	endfunction

endpackage

[sv/pde_stream_if.sv]
// ---------------------------------------------------------------------------
// Palette dither engine channels
// Pixel/palette item channel and palette index result channel.
// ---------------------------------------------------------------------------
interface pde_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] entry_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] prior_index;

	modport source (output valid, op, entry_index, red, green, blue, prior_index,
		input ready);
	modport sink (input valid, op, entry_index, red, green, blue, prior_index,
		output ready);
endinterface

interface pde_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] color_index;
	logic       frame_end;

	modport source (output valid, color_index, frame_end, input ready);
	modport sink (input valid, color_index, frame_end, output ready);
endinterface

[sv/pde_ctrl.sv]
// ---------------------------------------------------------------------------
// Palette dither engine controller
// Sequences accept, palette search, error diffusion, result and row clearing.
// ---------------------------------------------------------------------------
module pde_ctrl
	import pde_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.op_pixel) state_d = ST_ADJ;
				end
			end
			ST_ADJ: begin
				cmd.adj = 1'b1;
				if (sts.mode == MODE_PASS) state_d = ST_FINISH;
				else state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				cmd.srch_issue = 1'b1;
				if (sts.srch_last) state_d = ST_DRAIN1;
			end
			ST_DRAIN1: state_d = ST_DRAIN2;
			ST_DRAIN2: begin
				if (sts.mode == MODE_BAYER) state_d = ST_FINISH;
				else state_d = ST_PAL;
			end
			ST_PAL: begin
				cmd.best_load = 1'b1;
				state_d = ST_ERR;
			end
			ST_ERR: begin
				cmd.err_calc = 1'b1;
				state_d = ST_SP_RD;
			end
			ST_SP_RD: begin
				if (sts.tgt_en) begin
					cmd.sp_rd = 1'b1;
					state_d = ST_SP_WR;
				end else if (sts.tgt_last) begin
					state_d = ST_FINISH;
				end else begin
					cmd.tgt_next = 1'b1;
				end
			end
			ST_SP_WR: begin
				cmd.sp_wr = 1'b1;
				if (sts.tgt_last) begin
					state_d = ST_FINISH;
				end else begin
					cmd.tgt_next = 1'b1;
					state_d = ST_SP_RD;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					if (sts.last_col) state_d = ST_CLEAR;
					else state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[sv/pde_datapath.sv]
// ---------------------------------------------------------------------------
// Palette dither engine datapath
// Registers, palette and error-row memories, search pipeline and diffusion.
// ---------------------------------------------------------------------------
module pde_datapath
	import pde_pkg::*;
#(
	parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_op,
	input  logic [7:0]            in_entry_index,
	input  logic [7:0]            in_red,
	input  logic [7:0]            in_green,
	input  logic [7:0]            in_blue,
	input  logic [7:0]            in_prior_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_color_index,
	output logic                  out_frame_end,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int CW  = XW + 2;
	localparam int AW  = $clog2(ROWS * MAX_WIDTH);
	localparam int PAW = $clog2(PALETTE_DEPTH);
	localparam int PNW = $clog2(PALETTE_DEPTH + 1);

	// configuration
	mode_t                mode_q;
	logic [IMG_W_W-1:0]   width_q;
	logic [IMG_H_W-1:0]   height_q;
	logic [PAL_CNT_W-1:0] pcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_FS;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			pcount_q <= PCOUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:   mode_q   <= mode_t'(cfg_data[1:0]);
				CFG_WIDTH:  width_q  <= cfg_data[IMG_W_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[IMG_H_W-1:0];
				CFG_PCOUNT: pcount_q <= cfg_data[PAL_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	logic [WW-1:0]      w_eff;
	logic [IMG_H_W-1:0] h_eff;
	logic [PNW-1:0]     pc_eff;
	logic [PAW-1:0]     n_m1;

	always_comb begin
		if (width_q == '0) w_eff = WW'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(width_q);
		h_eff = (height_q == '0) ? IMG_H_W'(1) : height_q;
		if (pcount_q == '0) pc_eff = PNW'(1);
		else if (32'(pcount_q) > 32'(PALETTE_DEPTH)) pc_eff = PNW'(PALETTE_DEPTH);
		else pc_eff = PNW'(pcount_q);
		n_m1 = PAW'(pc_eff - PNW'(1));
	end

	// position
	logic [XW-1:0]      x_q;
	logic [IMG_H_W-1:0] y_q;
	logic [1:0]         slot_q;
	logic               lt1, lt2, yl1, yl2, last_col, last_row;

	assign lt1 = (CW'(x_q) + CW'(1)) < CW'(w_eff);
	assign lt2 = (CW'(x_q) + CW'(2)) < CW'(w_eff);
	assign yl1 = (17'(y_q) + 17'd1) < 17'(h_eff);
	assign yl2 = (17'(y_q) + 17'd2) < 17'(h_eff);
	assign last_col = !lt1;
	assign last_row = !yl1;

	function automatic logic [AW-1:0] row_base(input logic [1:0] s);
		case (s)
			2'd1:    return AW'(MAX_WIDTH);
			2'd2:    return AW'(2 * MAX_WIDTH);
			default: return '0;
		endcase
	endfunction

	// pixel item
	logic [7:0] red_q, green_q, blue_q, prior_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			red_q   <= in_red;
			green_q <= in_green;
			blue_q  <= in_blue;
			prior_q <= in_prior_index;
		end
	end

	// palette store
	logic [23:0]    pal_mem [PALETTE_DEPTH];
	logic [23:0]    pal_rd_q;
	logic [PAW-1:0] p_q, best_q;

	always_ff @(posedge clk) begin
		if (cmd.accept && in_op == OP_PAL && 9'(in_entry_index) < 9'(PALETTE_DEPTH))
			pal_mem[PAW'(in_entry_index)] <= {in_red, in_green, in_blue};
		if (cmd.srch_issue) pal_rd_q <= pal_mem[p_q];
		else if (cmd.best_load) pal_rd_q <= pal_mem[best_q];
	end

	// spread targets
	logic [2:0]  k_q;
	logic        tgt_en;
	logic [1:0]  tgt_dy;
	logic [XW-1:0] tgt_x;
	logic signed [12:0] tgt_num;
	logic [2:0]  tgt_sh;
	logic [2:0]  slot_sum;
	logic [1:0]  tgt_slot;
	logic [AW-1:0] tgt_addr, cur_addr;

	always_comb begin
		tgt_en  = 1'b0;
		tgt_dy  = 2'd0;
		tgt_x   = x_q;
		tgt_num = 13'sd1;
		tgt_sh  = 3'd3;
		if (mode_q == MODE_FS) begin
			tgt_sh = 3'd4;
			case (k_q)
				3'd0: begin
					tgt_en = lt1; tgt_x = x_q + XW'(1); tgt_num = 13'sd7;
				end
				3'd1: begin
					tgt_en = yl1 && x_q != '0; tgt_dy = 2'd1;
					tgt_x = x_q - XW'(1); tgt_num = 13'sd3;
				end
				3'd2: begin
					tgt_en = yl1; tgt_dy = 2'd1; tgt_num = 13'sd5;
				end
				3'd3: begin
					tgt_en = yl1 && lt1; tgt_dy = 2'd1; tgt_x = x_q + XW'(1);
				end
				default: tgt_en = 1'b0;
			endcase
		end else begin
			case (k_q)
				3'd0: begin tgt_en = lt1; tgt_x = x_q + XW'(1); end
				3'd1: begin tgt_en = lt2; tgt_x = x_q + XW'(2); end
				3'd2: begin
					tgt_en = yl1 && x_q != '0; tgt_dy = 2'd1; tgt_x = x_q - XW'(1);
				end
				3'd3: begin tgt_en = yl1; tgt_dy = 2'd1; end
				3'd4: begin
					tgt_en = yl1 && lt1; tgt_dy = 2'd1; tgt_x = x_q + XW'(1);
				end
				3'd5: begin tgt_en = yl2; tgt_dy = 2'd2; end
				default: tgt_en = 1'b0;
			endcase
		end
		slot_sum = 3'(slot_q) + 3'(tgt_dy);
		tgt_slot = (slot_sum >= 3'd3) ? 2'(slot_sum - 3'd3) : slot_sum[1:0];
		tgt_addr = row_base(tgt_slot) + AW'(tgt_x);
		cur_addr = row_base(slot_q) + AW'(x_q);
	end

	// error rows
	logic [ERR_W-1:0] err_mem [ROWS * MAX_WIDTH];
	logic [ERR_W-1:0] err_rd_q;
	logic [ERR_W-1:0] sp_wd;
	logic signed [8:0] e_q [3];
	logic [AW-1:0] clr_cnt_q, clr_base_q, clr_addr;
	logic          clr_all_q, clr_last;

	always_comb begin
		logic signed [12:0]     term;
		logic signed [CH_W-1:0] old;
		for (int c = 0; c < 3; c++) begin
			old  = err_rd_q[(2 - c) * CH_W +: CH_W];
			term = div_pow2(13'(e_q[c]) * tgt_num, tgt_sh);
			sp_wd[(2 - c) * CH_W +: CH_W] = CH_W'(old + CH_W'(term));
		end
	end

	assign clr_addr = clr_base_q + clr_cnt_q;
	assign clr_last = clr_all_q ? (clr_cnt_q == AW'(ROWS * MAX_WIDTH - 1))
		: (clr_cnt_q == AW'(MAX_WIDTH - 1));

	always_ff @(posedge clk) begin
		if (cmd.clr_step) err_mem[clr_addr] <= '0;
		else if (cmd.sp_wr) err_mem[tgt_addr] <= sp_wd;
		if (cmd.accept) err_rd_q <= err_mem[cur_addr];
		else if (cmd.sp_rd) err_rd_q <= err_mem[tgt_addr];
	end

	// adjusted pixel
	logic [7:0] px_q [3];
	logic [7:0] rgb [3];
	assign rgb[0] = red_q;
	assign rgb[1] = green_q;
	assign rgb[2] = blue_q;

	always_ff @(posedge clk) begin
		logic signed [10:0] off, sum;
		if (cmd.adj) begin
			for (int c = 0; c < 3; c++) begin
				if (mode_q == MODE_BAYER)
					off = $signed({3'b000, BAYER[{y_q[1:0], x_q[1:0]}], 4'b0000}) - 11'sd128;
				else
					off = 11'($signed(err_rd_q[(2 - c) * CH_W +: CH_W]));
				sum = $signed({3'b000, rgb[c]}) + off;
				if (sum < 0) px_q[c] <= 8'd0;
				else if (sum > 11'sd255) px_q[c] <= 8'd255;
				else px_q[c] <= sum[7:0];
			end
		end
		if (cmd.err_calc) begin
			e_q[0] <= $signed({1'b0, px_q[0]}) - $signed({1'b0, pal_rd_q[23:16]});
			e_q[1] <= $signed({1'b0, px_q[1]}) - $signed({1'b0, pal_rd_q[15:8]});
			e_q[2] <= $signed({1'b0, px_q[2]}) - $signed({1'b0, pal_rd_q[7:0]});
		end
	end

	// search pipeline
	logic           v_s1, v_s2, best_vld_q;
	logic [PAW-1:0] idx_s1, idx_s2;
	logic [17:0]    dist_s2, best_d_q, dist_sum;
	logic signed [17:0] dr, dg, db;

	assign dr = 18'($signed({1'b0, px_q[0]}) - $signed({1'b0, pal_rd_q[23:16]}));
	assign dg = 18'($signed({1'b0, px_q[1]}) - $signed({1'b0, pal_rd_q[15:8]}));
	assign db = 18'($signed({1'b0, px_q[2]}) - $signed({1'b0, pal_rd_q[7:0]}));
	assign dist_sum = 18'(dr * dr + dg * dg + db * db);

	always_ff @(posedge clk) begin
		idx_s1  <= p_q;
		idx_s2  <= idx_s1;
		dist_s2 <= dist_sum;
		if (v_s2 && (!best_vld_q || dist_s2 < best_d_q)) begin
			best_d_q <= dist_s2;
			best_q   <= idx_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			best_vld_q <= 1'b0;
			p_q        <= '0;
			k_q        <= '0;
		end else begin
			v_s1 <= cmd.srch_issue;
			v_s2 <= v_s1;
			if (cmd.adj) begin
				best_vld_q <= 1'b0;
				p_q        <= '0;
			end else begin
				if (v_s2) best_vld_q <= 1'b1;
				if (cmd.srch_issue) p_q <= p_q + PAW'(1);
			end
			if (cmd.err_calc) k_q <= '0;
			else if (cmd.tgt_next) k_q <= k_q + 3'd1;
		end
	end

	// result, position and clearing
	logic       out_valid_q;
	logic [7:0] color_q;
	logic       fend_q;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			color_q <= (mode_q == MODE_PASS) ? prior_q : 8'(best_q);
			fend_q  <= last_col && last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			slot_q      <= '0;
			clr_cnt_q   <= '0;
			clr_base_q  <= '0;
			clr_all_q   <= 1'b1;
		end else begin
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cmd.clr_step) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (cmd.finish) begin
				if (last_col) begin
					clr_cnt_q  <= '0;
					clr_all_q  <= last_row;
					clr_base_q <= last_row ? '0 : row_base(slot_q);
					x_q        <= '0;
					if (last_row) begin
						y_q    <= '0;
						slot_q <= '0;
					end else begin
						y_q    <= y_q + IMG_H_W'(1);
						slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
					end
				end else begin
					x_q <= x_q + XW'(1);
				end
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_color_index = color_q;
	assign out_frame_end   = fend_q;

	always_comb begin
		sts.op_pixel  = (in_op == OP_PIXEL);
		sts.mode      = mode_q;
		sts.srch_last = (p_q == n_m1);
		sts.tgt_en    = tgt_en;
		sts.tgt_last  = (k_q == 3'd5);
		sts.out_free  = !out_valid_q || out_ready;
		sts.last_col  = last_col;
		sts.clr_last  = clr_last;
	end

endmodule

[sv/palette_dither_engine_unit.sv]
// ---------------------------------------------------------------------------
// Palette dither engine
// Maps raster-order RGB pixels to palette indices with selectable dithering.
// ---------------------------------------------------------------------------
//  channel   dir   carries
//  px_in     in    palette load (op 0) or pixel (op 1)
//  idx_out   out   color_index, frame_end, one per pixel
//  cfg_*     in    register writes, index/data
//
//  Pass mode pixels skip the palette search. Bayer and diffusion pixels search
//  N entries, N the searched palette count, through the single palette read
//  port stepping one entry per cycle; diffusion pixels then spread the error.
//  End of row adds clearing of one error row and end of frame of all three
//  error rows; reset starts with the same full clearing pass.
//  A finished result waits in the output register while the next item enters.
`include "palette_dither_engine_unit_macros.svh"

module palette_dither_engine_unit
	import pde_pkg::*;
#(
	parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pde_in_if.sink                px_in,
	pde_out_if.source             idx_out
);

	cmd_t cmd;
	sts_t sts;

	pde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (px_in.valid),
		.in_ready (px_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pde_datapath #(
		.MAX_WIDTH     (MAX_WIDTH),
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_op           (px_in.op),
		.in_entry_index  (px_in.entry_index),
		.in_red          (px_in.red),
		.in_green        (px_in.green),
		.in_blue         (px_in.blue),
		.in_prior_index  (px_in.prior_index),
		.out_valid       (idx_out.valid),
		.out_ready       (idx_out.ready),
		.out_color_index (idx_out.color_index),
		.out_frame_end   (idx_out.frame_end),
		.cmd             (cmd),
		.sts             (sts)
	);

	`PDE_ASSERT_NEXT(a_pixel_busy, px_in.valid && px_in.ready && px_in.op == OP_PIXEL, !px_in.ready, "pixel transfer did not hold off input")
	`PDE_ASSERT_NEXT(a_spread_pair, cmd.sp_rd, cmd.sp_wr, "spread read not followed by write")
	`PDE_ASSERT_SAME(a_search_mode, cmd.srch_issue, sts.mode != MODE_PASS, "palette search in pass mode")

endmodule

[tb/pde_tb_chan_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Palette dither engine test channels
// Item types for the testbench, which reuses the block's own channel types.
// ---------------------------------------------------------------------------
// The block's channel interfaces live in its own interface file; this file
// only holds the shared item types used by stimulus, driver, predictor and
// monitor.
package pde_tb_pkg;
	import pde_pkg::*;

	typedef struct packed {
		op_t        op;
		logic [7:0] entry_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] prior_index;
	} px_item_t;

	typedef struct packed {
		logic [7:0] color_index;
		logic       frame_end;
	} idx_item_t;
endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Palette dither engine testbench
// Loads palettes and streams pixel frames through every dither mode and
// small geometries, including zero sizes, predicting each palette index and
// frame-end flag internally and comparing every transfer on the result channel.
// ---------------------------------------------------------------------------
module tb_top;
	import pde_pkg::*;
	import pde_tb_pkg::*;

	localparam int MAXW = 1024;
	localparam int LIMIT = 6000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pde_in_if px_in ();
	pde_out_if idx_out ();

	palette_dither_engine_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .px_in(px_in), .idx_out(idx_out)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [1:0] mode_r = MODE_FS;
	logic [10:0] width_r = 11'd1024;
	logic [15:0] height_r = 16'd1;
	logic [8:0] pcount_r = 9'd256;
	logic [23:0] palette [256];
	int err_acc [3][MAXW][3];
	int col_p, row_p;

	px_item_t pending_px[$];
	idx_item_t expected_idx[$];
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit failed = 0;
	int cycles = 0;
	int pal_loaded = 1;

	function automatic int clamp8(int v);
		return v < 0 ? 0 : (v > 255 ? 255 : v);
	endfunction

	function automatic int nearest_entry(int r, int g, int b);
		int n, best, bd, d, dr, dg, db;
		n = pcount_r == 0 ? 1 : (pcount_r > 256 ? 256 : pcount_r);
		best = 0;
		bd = -1;
		for (int p = 0; p < n; p++) begin
			dr = r - palette[p][23:16];
			dg = g - palette[p][15:8];
			db = b - palette[p][7:0];
			d = dr * dr + dg * dg + db * db;
			if (bd < 0 || d < bd) begin
				bd = d;
				best = p;
			end
		end
		return best;
	endfunction

	task automatic diffuse(int row, int x, int e[3], int num, int den);
		if (x >= MAXW)
			return;
		for (int c = 0; c < 3; c++)
			err_acc[row % 3][x][c] = 16'(err_acc[row % 3][x][c] + (e[c] * num) / den);
	endtask

	task automatic clear_errors(int row);
		for (int x = 0; x < MAXW; x++)
			for (int c = 0; c < 3; c++)
				err_acc[row][x][c] = 0;
	endtask

	task automatic predict_index(px_item_t it);
		int w, h, x, y, idx, t, s;
		int rgb[3], e[3];
		bit lc, lr;
		idx_item_t res;
		if (it.op == OP_PAL) begin
			palette[it.entry_index] = {it.red, it.green, it.blue};
			return;
		end
		w = width_r == 0 ? 1 : (width_r > MAXW ? MAXW : width_r);
		h = height_r == 0 ? 1 : height_r;
		x = col_p;
		y = row_p;
		lc = x + 1 >= w;
		lr = y + 1 >= h;
		rgb = '{it.red, it.green, it.blue};
		if (mode_r == MODE_PASS) begin
			idx = it.prior_index;
		end else if (mode_r == MODE_BAYER) begin
			t = BAYER[(y % 4) * 4 + (x % 4)] * 16 - 128;
			for (int c = 0; c < 3; c++)
				rgb[c] = clamp8(rgb[c] + t);
			idx = nearest_entry(rgb[0], rgb[1], rgb[2]);
		end else begin
			s = y % 3;
			for (int c = 0; c < 3; c++)
				rgb[c] = clamp8(rgb[c] + err_acc[s][x][c]);
			idx = nearest_entry(rgb[0], rgb[1], rgb[2]);
			e[0] = rgb[0] - palette[idx][23:16];
			e[1] = rgb[1] - palette[idx][15:8];
			e[2] = rgb[2] - palette[idx][7:0];
			if (mode_r == MODE_FS) begin
				if (!lc) diffuse(y, x + 1, e, 7, 16);
				if (!lr) begin
					if (x > 0) diffuse(y + 1, x - 1, e, 3, 16);
					diffuse(y + 1, x, e, 5, 16);
					if (!lc) diffuse(y + 1, x + 1, e, 1, 16);
				end
			end else begin
				if (x + 1 < w) diffuse(y, x + 1, e, 1, 8);
				if (x + 2 < w) diffuse(y, x + 2, e, 1, 8);
				if (y + 1 < h) begin
					if (x > 0) diffuse(y + 1, x - 1, e, 1, 8);
					diffuse(y + 1, x, e, 1, 8);
					if (x + 1 < w) diffuse(y + 1, x + 1, e, 1, 8);
				end
				if (y + 2 < h) diffuse(y + 2, x, e, 1, 8);
			end
		end
		res.color_index = idx[7:0];
		res.frame_end = lc && lr;
		expected_idx.push_back(res);
		if (lc && lr) begin
			for (int r = 0; r < 3; r++)
				clear_errors(r);
			col_p = 0;
			row_p = 0;
		end else if (lc) begin
			clear_errors(y % 3);
			col_p = 0;
			row_p = (y + 1) & 16'hFFFF;
		end else begin
			col_p = x + 1;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_in.valid <= 1'b0;
			px_in.op <= OP_PAL;
			px_in.entry_index <= '0;
			px_in.red <= '0;
			px_in.green <= '0;
			px_in.blue <= '0;
			px_in.prior_index <= '0;
		end else begin
			if (px_in.valid && px_in.ready) begin
				predict_index(pending_px.pop_front());
			end
			if ((!px_in.valid || px_in.ready) && pending_px.size() > 0 &&
					!(px_in.valid && pending_px.size() == 1) &&
					$urandom_range(99) >= send_idle_pct) begin
				px_item_t nx;
				nx = (px_in.valid && px_in.ready) ? pending_px[0] : pending_px[0];
				px_in.valid <= 1'b1;
				{px_in.op, px_in.entry_index, px_in.red, px_in.green, px_in.blue,
					px_in.prior_index} <= nx;
			end else if (!px_in.valid || px_in.ready) begin
				px_in.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_out.ready <= 1'b0;
		end else begin
			if (idx_out.valid && idx_out.ready) begin
				if (expected_idx.size() == 0) begin
					$display("%0t: unexpected result index %0d frame_end %0b", $time,
						idx_out.color_index, idx_out.frame_end);
					failed = 1;
				end else begin
					idx_item_t ex;
					ex = expected_idx.pop_front();
					if (ex.color_index !== idx_out.color_index) begin
						$display("%0t: color_index expected %0d actual %0d", $time,
							ex.color_index, idx_out.color_index);
						failed = 1;
					end
					if (ex.frame_end !== idx_out.frame_end) begin
						$display("%0t: frame_end expected %0b actual %0b", $time,
							ex.frame_end, idx_out.frame_end);
						failed = 1;
					end
				end
			end
			idx_out.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("palette_dither_engine_unit regression: fail");
			$finish;
		end
	end

	task automatic write_reg(cfg_idx_t i, int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= i;
		cfg_data <= v[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (i)
			CFG_MODE: mode_r = v[1:0];
			CFG_WIDTH: width_r = v[10:0];
			CFG_HEIGHT: height_r = v[15:0];
			default: pcount_r = v[8:0];
		endcase
	endtask

	task automatic drain();
		while (pending_px.size() > 0 || px_in.valid || expected_idx.size() > 0)
			@(posedge clk);
		repeat (3 * MAXW + 300) @(posedge clk);
	endtask

	function automatic px_item_t pal_item(int e, int r, int g, int b);
		px_item_t it;
		it = '{OP_PAL, e[7:0], r[7:0], g[7:0], b[7:0], 8'($urandom)};
		return it;
	endfunction

	function automatic px_item_t pixel(int r, int g, int b, int p);
		px_item_t it;
		it = '{OP_PIXEL, 8'($urandom), r[7:0], g[7:0], b[7:0], p[7:0]};
		return it;
	endfunction

	task automatic load_palette(int n);
		for (int e = 0; e < n; e++)
			pending_px.push_back(pal_item(e, $urandom_range(255), $urandom_range(255),
				$urandom_range(255)));
		if (n > pal_loaded)
			pal_loaded = n;
	endtask

	task automatic frame(int w, int h, int md, int pc);
		write_reg(CFG_MODE, md);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_PCOUNT, pc);
		for (int i = 0; i < (w == 0 ? 1 : w) * (h == 0 ? 1 : h); i++)
			pending_px.push_back(pixel($urandom_range(255), $urandom_range(255),
				$urandom_range(255), $urandom_range(255)));
		drain();
	endtask

	initial begin
		int sent;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes and all four modes, palette indices at both ends
		pending_px.push_back(pal_item(0, 0, 0, 0));
		pending_px.push_back(pal_item(1, 255, 255, 255));
		pending_px.push_back(pal_item(2, 0, 0, 0));
		pending_px.push_back(pal_item(255, 255, 0, 255));
		drain();
		frame(2, 2, MODE_PASS, 0);
		pending_px.push_back(pal_item(3, 128, 128, 128));
		drain();
		frame(0, 0, MODE_FS, 4);
		frame(3, 2, MODE_ATK, 3);
		frame(4, 2, MODE_BAYER, 2);
		load_palette(256);
		drain();
		frame(1, 3, MODE_FS, 9'd300);
		// random phases
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 19 : (ph == 1 ? 61 : 0);
			recv_idle_pct = ph == 0 ? 61 : (ph == 1 ? 19 : 0);
			sent = 0;
			while (sent < 50) begin
				int w, h, md;
				if ($urandom_range(3) == 0) begin
					load_palette($urandom_range(1, 16));
					drain();
				end
				w = $urandom_range(1, 6);
				h = $urandom_range(1, 5);
				md = $urandom_range(3);
				frame(w, h, md, $urandom_range(1, pal_loaded < 16 ? pal_loaded : 16));
				sent += w * h;
			end
		end
		drain();
		if (!failed)
			$display("palette_dither_engine_unit regression: pass");
		else
			$display("palette_dither_engine_unit regression: fail");
		$finish;
	end
endmodule
